// ===== src/tec_pkg.sv =====
// Shared constants, codes and character helpers for the text console terminal.
// No dependencies; the top level imports it.
package tec_pkg;

   localparam int COLS_DEF = 128;
   localparam int ROWS_DEF = 16;

   localparam int OP_W    = 2;
   localparam int BYTE_W  = 8;
   localparam int RCOL_W  = 7;
   localparam int RROW_W  = 4;
   localparam int PARSE_W = 2;
   localparam int CNT_W   = 8;

   typedef enum logic [OP_W-1:0] {
      OP_FEED  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [PARSE_W-1:0] {
      PS_NORMAL  = 2'd0,
      PS_ESC     = 2'd1,
      PS_BRACKET = 2'd2
   } parse_type;

   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_RBRK  = 8'h5D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_K     = 8'h4B;

   // Debug text position of the first character of a plain "[hh]" dump.
   localparam logic [2:0] DBG_HEX_START = 3'd3;
   localparam logic [2:0] DBG_LAST      = 3'd6;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (CH_ZERO + {4'd0, nib}) : (8'h37 + {4'd0, nib});
   endfunction

   // Character at a position of the debug string "*E[[hh]".
   function automatic logic [7:0] dbg_char(input logic [2:0] idx, input logic [7:0] b);
      logic [7:0] ch;
      unique case (idx)
         3'd0: ch = CH_STAR;
         3'd1: ch = CH_E;
         3'd2: ch = CH_LBRK;
         3'd3: ch = CH_LBRK;
         3'd4: ch = hex_char(b[7:4]);
         3'd5: ch = hex_char(b[3:0]);
         default: ch = CH_RBRK;
      endcase
      dbg_char = ch;
   endfunction

endpackage

// ===== src/tec_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; used for the screen store of the terminal.
module tec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/text_console_escape_terminal_core.sv =====
// Character-cell text terminal: screen store, cursor and escape parser.
// Depends on tec_pkg and on tec_ram for the screen store.
//
// Use: every request item carries an op. Feed (op 0) hands one byte to the
// parser, read (op 1) returns the cell at read_col/read_row, clear (op 2)
// blanks the screen and homes the cursor. Each item gives exactly one
// response item with the cell byte (zero unless a read), the cursor and the
// parser state after the item. Items move when valid is high and stall low.
// The block takes one item at a time: req_stall stays high while an item is
// in work. The work of an item is set by the single screen memory, which
// writes one cell per cycle: a printed character writes one cell, a debug
// dump a run of cells, an erase to end of line the rest of the row, and a
// clear or a scroll the whole screen. A scroll streams the memory with a
// read COLS cells ahead of the write.
// After reset the screen memory is swept to zero; req_stall is high
// meanwhile. The response sits in an output register, so a stalled receiver
// does not block the next request from being taken; only the completion of
// that next item waits for the register.
module text_console_escape_terminal_core
   import tec_pkg::*;
#(
   parameter int COLS = COLS_DEF,
   parameter int ROWS = ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_op,
   input  logic [BYTE_W-1:0]  req_byte_in,
   input  logic [RCOL_W-1:0]  req_read_col,
   input  logic [RROW_W-1:0]  req_read_row,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_cell_char,
   output logic [RCOL_W-1:0]  rsp_cursor_col,
   output logic [RROW_W-1:0]  rsp_cursor_row,
   output logic [PARSE_W-1:0] rsp_parse_state
);

   localparam int DEPTH = COLS * ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(COLS);
   // The line may point one past the last row until the scroll resolves it.
   localparam int LW    = $clog2(ROWS + 1);
   localparam int N1    = COLS * (ROWS - 1);

   localparam logic [AW-1:0] ADDR_LAST   = AW'(DEPTH - 1);
   localparam logic [AW-1:0] ADDR_LASTRW = AW'(N1);
   localparam logic [CW-1:0] COL_LAST    = CW'(COLS - 1);
   localparam logic [LW-1:0] LINE_LAST   = LW'(ROWS - 1);
   localparam logic [LW-1:0] LINE_OVER   = LW'(ROWS);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_PRINT, ST_KCLR, ST_SCROLL, ST_ZROW, ST_CLEAR,
      ST_RDATA, ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [LW-1:0]    line_ff, line_in;
   parse_type        esc_ff, esc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]    sweep_ff, sweep_in;
   logic [2:0]       idx_ff, idx_in;
   logic             lit_ff, lit_in;
   logic [7:0]       code_ff, code_in;
   logic             inr_ff, inr_in;
   logic [7:0]       cell_ff, cell_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_cell_ff, rsp_cell_in;
   logic [CW-1:0]    rsp_col_ff, rsp_col_in;
   logic [LW-1:0]    rsp_line_ff, rsp_line_in;
   parse_type        rsp_ps_ff, rsp_ps_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   logic [11:0]     cnt_mul;
   logic [8:0]      col_w, cnt_w;
   logic [7:0]      pchar;
   logic [CW-1:0]   col_step;
   logic [LW-1:0]   line_step;
   logic [CW+6:0]   col_x;
   logic [LW+3:0]   line_x;

   function automatic logic [AW-1:0] cell_addr(input logic [LW-1:0] ln,
                                                input logic [CW-1:0] cl);
      cell_addr = AW'(int'(ln) * COLS + int'(cl));
   endfunction

   tec_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign cnt_mul   = {4'd0, cnt_ff} * 12'd10 + {4'd0, req_byte_in - CH_ZERO};
   assign col_w     = 9'(col_ff);
   assign cnt_w     = {1'b0, cnt_ff};
   assign pchar     = lit_ff ? code_ff : dbg_char(idx_ff, code_ff);
   assign col_step  = (col_ff == COL_LAST) ? '0 : col_ff + CW'(1);
   assign line_step = (col_ff == COL_LAST) ? line_ff + LW'(1) : line_ff;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      esc_in       = esc_ff;
      cnt_in       = cnt_ff;
      sweep_in     = sweep_ff;
      idx_in       = idx_ff;
      lit_in       = lit_ff;
      code_in      = code_ff;
      inr_in       = inr_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in  = rsp_cell_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_ps_in    = rsp_ps_ff;
      ram_we       = 1'b0;
      ram_waddr    = sweep_ff;
      ram_wdata    = '0;
      ram_raddr    = sweep_ff;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_we = 1'b1;
            if (sweep_ff == ADDR_LAST) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            ram_raddr = AW'(int'(req_read_row) * COLS + int'(req_read_col));
            if (req_valid) begin
               cell_in  = '0;
               state_in = ST_DONE;
               unique case (op_type'(req_op))
                  OP_READ: begin
                     inr_in   = (int'(req_read_col) < COLS) && (int'(req_read_row) < ROWS);
                     state_in = ST_RDATA;
                  end
                  OP_CLEAR: begin
                     col_in   = '0;
                     line_in  = '0;
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  OP_NONE: begin
                     state_in = ST_DONE;
                  end
                  OP_FEED: begin
                     code_in = req_byte_in;
                     lit_in  = 1'b0;
                     idx_in  = '0;
                     priority case (esc_ff)
                        PS_ESC: begin
                           esc_in = (req_byte_in == CH_LBRK) ? PS_BRACKET : PS_NORMAL;
                        end
                        PS_BRACKET: begin
                           esc_in = PS_NORMAL;
                           if (req_byte_in >= CH_ZERO && req_byte_in <= CH_NINE) begin
                              cnt_in = (cnt_mul > 12'd255) ? 8'd255 : cnt_mul[7:0];
                              esc_in = PS_BRACKET;
                           end else if (req_byte_in == CH_D) begin
                              if (cnt_ff == '0) begin
                                 if (col_ff != '0) col_in = col_ff - CW'(1);
                              end else if (col_w > cnt_w) begin
                                 col_in = CW'(col_w - cnt_w);
                              end else begin
                                 col_in = '0;
                              end
                           end else if (req_byte_in == CH_K) begin
                              sweep_in = cell_addr(line_ff, col_ff);
                              state_in = ST_KCLR;
                           end else if (req_byte_in == CH_A || req_byte_in == CH_B ||
                                        req_byte_in == CH_C || req_byte_in == CH_H ||
                                        req_byte_in == CH_F) begin
                              state_in = ST_DONE;
                           end else begin
                              state_in = ST_PRINT;
                           end
                        end
                        default: begin
                           if (req_byte_in == CH_LF) begin
                              if (line_ff == LINE_LAST) begin
                                 sweep_in = '0;
                                 state_in = ST_SCROLL;
                              end else begin
                                 line_in = line_ff + LW'(1);
                              end
                           end else if (req_byte_in == CH_CR) begin
                              col_in = '0;
                           end else if (req_byte_in == CH_BS) begin
                              if (col_ff != '0) col_in = col_ff - CW'(1);
                           end else if (req_byte_in == CH_ESC) begin
                              cnt_in = '0;
                              esc_in = PS_ESC;
                           end else if (req_byte_in < CH_SPACE) begin
                              idx_in   = DBG_HEX_START;
                              state_in = ST_PRINT;
                           end else begin
                              lit_in   = 1'b1;
                              state_in = ST_PRINT;
                           end
                        end
                     endcase
                  end
               endcase
            end
         end

         ST_PRINT: begin
            // Characters that land below the last row are dropped.
            ram_we    = (line_ff < LINE_OVER);
            ram_waddr = cell_addr(line_ff, col_ff);
            ram_wdata = pchar;
            col_in    = col_step;
            line_in   = line_step;
            idx_in    = idx_ff + 3'd1;
            if (lit_ff || idx_ff == DBG_LAST) begin
               if (line_step == LINE_OVER) begin
                  line_in  = LINE_LAST;
                  sweep_in = '0;
                  state_in = ST_SCROLL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_KCLR: begin
            ram_we = 1'b1;
            if (sweep_ff == cell_addr(line_ff, COL_LAST)) begin
               state_in = ST_DONE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end

         ST_SCROLL: begin
            // Read one row ahead; the data lands in the write in the next cycle.
            ram_raddr = sweep_ff + AW'(COLS);
            ram_we    = (sweep_ff != '0);
            ram_waddr = sweep_ff - AW'(1);
            ram_wdata = ram_rdata;
            if (sweep_ff == ADDR_LASTRW) begin
               state_in = ST_ZROW;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end

         ST_ZROW: begin
            ram_we = 1'b1;
            if (sweep_ff == ADDR_LAST) begin
               state_in = ST_DONE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end

         ST_RDATA: begin
            cell_in  = inr_ff ? ram_rdata : 8'd0;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = cell_ff;
               rsp_col_in   = col_ff;
               rsp_line_in  = line_ff;
               rsp_ps_in    = esc_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= '0;
         line_ff      <= '0;
         esc_ff       <= PS_NORMAL;
         cnt_ff       <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         esc_ff       <= esc_in;
         cnt_ff       <= cnt_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      lit_ff      <= lit_in;
      code_ff     <= code_in;
      inr_ff      <= inr_in;
      cell_ff     <= cell_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_line_ff <= rsp_line_in;
      rsp_ps_ff   <= rsp_ps_in;
   end

   assign col_x           = {7'd0, rsp_col_ff};
   assign line_x          = {4'd0, rsp_line_ff};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_char   = rsp_cell_ff;
   assign rsp_cursor_col  = col_x[6:0];
   assign rsp_cursor_row  = line_x[3:0];
   assign rsp_parse_state = rsp_ps_ff;

   // A scroll always leaves the cursor on the last row.
   a_scroll_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL || state_ff == ST_ZROW) |-> (line_ff == LINE_LAST))
      else $error("cursor not on last row during scroll");

   // Between items the cursor sits inside the screen.
   a_idle_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (line_ff < LINE_OVER))
      else $error("cursor line out of range while idle");

   // A response is only loaded from the completion state.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && state_ff != ST_DONE) |=> !rsp_valid_ff)
      else $error("response appeared without a finished item");

   // The reset sweep never yields a response.
   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !rsp_valid_ff)
      else $error("response during the reset clearing pass");

endmodule
